/* hw/rtl/gol_pkg.sv */
// shared types, constants and overlap helper for the grid objectness loss block
package gol_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CELL   = 2'd2;

  localparam logic REG_GRID_SIDE = 1'b0;
  localparam logic REG_SCALE     = 1'b1;

  localparam int POS_W   = 6;
  localparam int SIDE_W  = 7;
  localparam int OVL_W   = 27;
  localparam int INTER_W = 36;
  localparam int UNI_W   = 47;
  localparam int REM_W   = 48;
  localparam int QUO_W   = 17;
  localparam int LOSS_W  = 48;

  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};
  localparam logic [UNI_W-1:0] CELL_AREA = UNI_W'(64'h4_0000_0000);

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } truth_t;

  // overlap of cell span [c*2^17, (c+1)*2^17) with truth span (2x -/+ w)*s
  function automatic logic signed [OVL_W-1:0] span_ovl(
    input logic [POS_W-1:0] c,
    input logic [15:0] x,
    input logic [15:0] w,
    input logic [SIDE_W-1:0] s
  );
    logic signed [OVL_W-1:0] cl;
    logic signed [OVL_W-1:0] cr;
    logic signed [OVL_W-1:0] ctr;
    logic signed [OVL_W-1:0] tl;
    logic signed [OVL_W-1:0] tr;
    logic signed [OVL_W-1:0] sv;
    logic signed [OVL_W-1:0] l;
    logic signed [OVL_W-1:0] r;
    cl  = $signed({{(OVL_W-POS_W-17){1'b0}}, c, 17'b0});
    cr  = cl + $signed(OVL_W'(131072));
    ctr = $signed({{(OVL_W-17){1'b0}}, x, 1'b0});
    sv  = $signed({{(OVL_W-SIDE_W){1'b0}}, s});
    tl  = OVL_W'((ctr - $signed({{(OVL_W-16){1'b0}}, w})) * sv);
    tr  = OVL_W'((ctr + $signed({{(OVL_W-16){1'b0}}, w})) * sv);
    l   = (cl > tl) ? cl : tl;
    r   = (cr < tr) ? cr : tr;
    return r - l;
  endfunction

endpackage

/* hw/rtl/gol_div.sv */
// iterative restoring divider, one quotient bit per cycle, for the iou ratio
module gol_div
  import gol_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [INTER_W-1:0] num,
  input  logic [UNI_W-1:0]   den,
  output logic               done,
  output logic [QUO_W-1:0]   quo
);

  logic             busy_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [UNI_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic             ge;
  logic [REM_W-1:0] rsub;

  assign ge   = rem_r >= {1'b0, den_r};
  assign rsub = ge ? rem_r - {1'b0, den_r} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num);
      den_r <= den;
      quo_r <= '0;
      cnt_r <= 5'(QUO_W - 1);
    end else if (busy_r) begin
      rem_r <= {rsub[REM_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/grid_objectness_loss.sv */
// top level: truth store, per-cell sequencer, loss arithmetic and result register
// A cell beat walks the stored truths one at a time. Each truth takes a store read, the span
// overlap and a step on to the next truth, all that a truth missing the cell takes.
// A truth whose spans touch the cell adds the area products and the union, and one with a
// nonzero intersection adds a pass through the shared bit-serial divider. States P1 to P4
// then form delta, gradient and the loss sum, and the input side stays busy until the result
// is registered; a stalled result register holds the sequencer in P4. Clear and append beats
// are taken while idle. The input side is not ready while a cell is in work; a finished
// result waits in the output register while the next beat is taken.
module grid_objectness_loss
  import gol_pkg::*;
#(
  parameter int MAX_TRUTHS = 32,
  parameter int MAX_SIDE   = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,   // box_x, box_y, box_w, box_h, cell_prob
  input  logic [1:0]    in_tuser,   // op
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // object_target, best_overlap, delta, gradient, loss, pad
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int AW = (MAX_TRUTHS > 1) ? $clog2(MAX_TRUTHS) : 1;
  localparam int CW = $clog2(MAX_TRUTHS + 1);
  localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_OVL  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_UNI  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_NXT  = 4'd6;
  localparam logic [3:0] S_P1   = 4'd7;
  localparam logic [3:0] S_P2   = 4'd8;
  localparam logic [3:0] S_P3   = 4'd9;
  localparam logic [3:0] S_P4   = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic [5:0]  grid_side_r;
  logic [15:0] scale_r;

  truth_t mem [MAX_TRUTHS];
  truth_t rd_data_r;

  logic [CW-1:0] count_r;
  logic          closed_r;
  logic [CW-1:0] t_r;
  logic [PW-1:0] col_r;
  logic [PW-1:0] row_r;

  logic [15:0] p_r;
  logic        last_r;
  logic        target_r;
  logic [QUO_W-1:0] best_r;

  logic [17:0]        ow_r, oh_r;
  logic [23:0]        aw_r, ah_r;
  logic [INTER_W-1:0] inter_r;
  logic [LOSS_W-1:0]  tarea_r;

  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [UNI_W-1:0]   uni;

  logic        neg_r;
  logic [32:0] prod1_r;
  logic [19:0] mag_r;
  logic [32:0] pq_r;
  logic [52:0] gprod_r;
  logic [39:0] sq_r;
  logic [LOSS_W-1:0] loss_sum_r;

  logic          out_valid_r;
  logic [111:0]  out_data_r;
  logic          out_last_r;

  logic [15:0] in_x, in_y, in_w, in_h, in_p;
  logic        in_acc;
  logic [SIDE_W-1:0] side;
  logic signed [OVL_W-1:0] ow, oh;
  logic [33:0] mag_sum;
  logic [21:0] mag_full;
  logic [53:0] g_sum;
  logic [20:0] gmag;
  logic [20:0] delta_v, grad_v;
  logic [LOSS_W:0] loss_add;
  logic [LOSS_W-1:0] loss_new;
  logic        out_free;
  logic [SIDE_W-1:0] col_inc, row_inc;

  assign in_x = in_tdata[15:0];
  assign in_y = in_tdata[31:16];
  assign in_w = in_tdata[47:32];
  assign in_h = in_tdata[63:48];
  assign in_p = in_tdata[79:64];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (grid_side_r == 6'd0) begin
      side = SIDE_W'(1);
    end else if (SIDE_W'(grid_side_r) > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_side_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= 6'd13;
      scale_r     <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_SIDE: grid_side_r <= cfg_data[5:0];
        REG_SCALE:     scale_r     <= cfg_data;
        default:       ;
      endcase
    end
  end

  // truth store
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_APPEND && !closed_r && in_x != 16'd0 &&
        count_r < CW'(MAX_TRUTHS)) begin
      mem[count_r[AW-1:0]] <= '{h: in_h, w: in_w, y: in_y, x: in_x};
    end
    rd_data_r <= mem[t_r[AW-1:0]];
  end

  assign ow = span_ovl(POS_W'(col_r), rd_data_r.x, rd_data_r.w, side);
  assign oh = span_ovl(POS_W'(row_r), rd_data_r.y, rd_data_r.h, side);
  assign uni = UNI_W'(CELL_AREA + tarea_r - LOSS_W'(inter_r));
  assign div_start = (state_r == S_UNI) && (inter_r != '0);

  gol_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (inter_r),
    .den   (uni),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OP_CELL) begin
          state_nxt = (count_r == '0) ? S_P1 : S_RD;
        end
      end
      S_RD:  state_nxt = S_OVL;
      S_OVL: state_nxt = (ow < 0 || oh < 0) ? S_NXT : S_MUL;
      S_MUL: state_nxt = S_UNI;
      S_UNI: state_nxt = (inter_r != '0) ? S_DIV : S_NXT;
      S_DIV: state_nxt = div_done ? S_NXT : S_DIV;
      S_NXT: state_nxt = (t_r + CW'(1) == count_r) ? S_P1 : S_RD;
      S_P1:  state_nxt = S_P2;
      S_P2:  state_nxt = S_P3;
      S_P3:  state_nxt = S_P4;
      S_P4:  state_nxt = out_free ? S_IDLE : S_P4;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign col_inc = SIDE_W'(col_r) + SIDE_W'(1);
  assign row_inc = SIDE_W'(row_r) + SIDE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      closed_r   <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      loss_sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == OP_CLEAR) begin
        count_r  <= '0;
        closed_r <= 1'b0;
        col_r    <= '0;
        row_r    <= '0;
      end else if (in_acc && in_tuser == OP_APPEND && !closed_r) begin
        if (in_x == 16'd0) begin
          closed_r <= 1'b1;
        end else if (count_r < CW'(MAX_TRUTHS)) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (state_r == S_P4 && out_free) begin
        loss_sum_r <= last_r ? '0 : loss_new;
        if (col_inc >= side) begin
          col_r <= '0;
          row_r <= (row_inc >= side) ? '0 : PW'(row_inc);
        end else begin
          col_r <= PW'(col_inc);
        end
      end
    end
  end

  // per-truth datapath and post arithmetic
  assign mag_sum  = {1'b0, prod1_r} + 34'd2048;
  assign mag_full = mag_sum[33:12];
  assign g_sum    = {1'b0, gprod_r} + 54'h8000_0000;
  assign gmag     = g_sum[52:32];
  assign delta_v  = neg_r ? -{1'b0, mag_r} : {1'b0, mag_r};
  assign grad_v   = neg_r ? gmag : -gmag;
  assign loss_add = {1'b0, loss_sum_r} + (LOSS_W + 1)'(sq_r);
  assign loss_new = loss_add[LOSS_W] ? LOSS_MAX : loss_add[LOSS_W-1:0];

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        p_r      <= in_p;
        last_r   <= in_tlast;
        t_r      <= '0;
        best_r   <= '0;
        target_r <= 1'b0;
      end
      S_OVL: begin
        ow_r <= ow[17:0];
        oh_r <= oh[17:0];
        aw_r <= 24'({rd_data_r.w, 1'b0} * side);
        ah_r <= 24'({rd_data_r.h, 1'b0} * side);
      end
      S_MUL: begin
        inter_r <= INTER_W'(ow_r * oh_r);
        tarea_r <= LOSS_W'(aw_r * ah_r);
      end
      S_UNI: begin
        if (inter_r != '0) begin
          target_r <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done && div_quo > best_r) begin
          best_r <= div_quo;
        end
      end
      S_NXT: t_r <= t_r + CW'(1);
      S_P1: begin
        neg_r   <= !target_r && p_r != 16'd0;
        prod1_r <= 33'((target_r ? 17'd65536 - {1'b0, p_r} : {1'b0, p_r}) * scale_r);
      end
      S_P2: begin
        mag_r <= (mag_full > 22'd1048575) ? 20'hFFFFF : mag_full[19:0];
        pq_r  <= 33'(p_r * (17'd65536 - {1'b0, p_r}));
      end
      S_P3: begin
        gprod_r <= 53'(mag_r * pq_r);
        sq_r    <= 40'(mag_r * mag_r);
      end
      S_P4: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_P4 && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_P4 && out_free) begin
      out_data_r <= {4'b0, (last_r ? loss_new : LOSS_W'(0)), grad_v, delta_v,
                     best_r, target_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/gol_chk.sv */
// port-level checks for the grid objectness loss block and their bind
module gol_chk
  import gol_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic [1:0]    in_tuser,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [111:0]  out_tdata,
  input logic          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_cell_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CELL |=> !in_tready)
    else $error("input ready right after a cell beat");

  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[107:60] == '0)
    else $error("loss nonzero on a non-final cell");

  a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:1] <= 17'd65536)
    else $error("best overlap above one");

  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[17:1] == '0)
    else $error("overlap without target");

endmodule

bind grid_objectness_loss gol_chk u_gol_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
